// File: design/digitizer_event_unpacker_unit_defines.svh
// Assertion macros used by the checker file of the event unpacker.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef DIGITIZER_EVENT_UNPACKER_UNIT_DEFINES_SVH
`define DIGITIZER_EVENT_UNPACKER_UNIT_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define DEU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("unpacker check failed");

// Condition holds in the cycle after the trigger.
`define DEU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("unpacker check failed");

`endif

// File: design/deu_pkg.sv
// Shared types, constants and helpers for the digitizer event unpacker.
// No dependencies; used by all unpacker modules and the checker.
`timescale 1ns / 1ps

package deu_pkg;

	localparam int MAX_GROUPS         = 4;
	localparam int CHANNELS_PER_GROUP = 8;
	localparam int SAMPLE_BITS        = 12;
	localparam int TIME_BITS          = 30;
	localparam int MAX_RES            = 5;
	localparam int RES_CNT_W          = $clog2(MAX_RES + 1);

	localparam logic [3:0] HDR_MARKER = 4'hA;

	// floor(x / 3) for 12-bit x equals (x * 2731) >> 13
	localparam logic [11:0] DIV3_RECIP = 12'd2731;
	localparam int          DIV3_SHIFT = 13;

	localparam logic [3:0] KIND_BAD     = 4'd0;
	localparam logic [3:0] KIND_LEN     = 4'd1;
	localparam logic [3:0] KIND_GMASK   = 4'd2;
	localparam logic [3:0] KIND_LVDS    = 4'd3;
	localparam logic [3:0] KIND_EVNUM   = 4'd4;
	localparam logic [3:0] KIND_TTAG    = 4'd5;
	localparam logic [3:0] KIND_GHDR    = 4'd6;
	localparam logic [3:0] KIND_SAMPLE  = 4'd7;
	localparam logic [3:0] KIND_TSAMPLE = 4'd8;
	localparam logic [3:0] KIND_TTIME   = 4'd9;

	typedef struct packed {
		logic [3:0]  kind;
		logic [1:0]  group;
		logic [2:0]  channel;
		logic [10:0] sample_index;
		logic [59:0] value;
		logic        trigger_present;
		logic [1:0]  frequency;
		logic        last;
	} res_t;

	// Results of one input word, slot 0 goes out first
	typedef struct packed {
		logic [RES_CNT_W-1:0]   cnt;
		res_t [MAX_RES-1:0]     item;
	} res_set_t;

	typedef struct packed {
		logic       found;
		logic [1:0] idx;
	} grp_sel_t;

	function automatic res_t mk_res(input logic [3:0] kind, input logic [1:0] grp,
			input logic [2:0] ch, input logic [10:0] idx, input logic [59:0] val,
			input logic trig, input logic [1:0] freq, input logic last);
		res_t r;
		r.kind            = kind;
		r.group           = grp;
		r.channel         = ch;
		r.sample_index    = idx;
		r.value           = val;
		r.trigger_present = trig;
		r.frequency       = freq;
		r.last            = last;
		return r;
	endfunction

	// Lowest enabled group at or above from
	function automatic grp_sel_t next_group(input logic [MAX_GROUPS-1:0] mask,
			input logic [2:0] from);
		grp_sel_t r;
		r = '0;
		for (int g = MAX_GROUPS - 1; g >= 0; g--) begin
			if (mask[g] && (3'(g) >= from)) begin
				r.found = 1'b1;
				r.idx   = 2'(g);
			end
		end
		return r;
	endfunction

endpackage

// File: design/deu_decode.sv
// Parse state machine and per-word result builder of the event unpacker.
// Depends on deu_pkg.
`timescale 1ns / 1ps

module deu_decode #(
	parameter int NUM_GROUPS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic [31:0]        word,
	input  logic               sof,
	output deu_pkg::res_set_t  set
);
	import deu_pkg::*;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_MASK  = 3'd1;
	localparam logic [2:0] PH_EVNR  = 3'd2;
	localparam logic [2:0] PH_TTAG  = 3'd3;
	localparam logic [2:0] PH_GHDR  = 3'd4;
	localparam logic [2:0] PH_SAMP  = 3'd5;
	localparam logic [2:0] PH_TRIG  = 3'd6;
	localparam logic [2:0] PH_GTIME = 3'd7;

	logic [2:0]            ph_q, ph_d;
	logic [1:0]            wig_q, wig_d;
	logic [10:0]           cnt_q, cnt_d;
	logic [10:0]           spc_q, spc_d;
	logic [NUM_GROUPS-1:0] en_q, en_d;
	logic [1:0]            cg_q, cg_d;
	logic                  trg_q, trg_d;
	logic [7:0]            carry_q, carry_d, carry_u;
	logic [1:0]            freq_q, freq_d;
	logic [TIME_BITS-1:0]  gt_q [MAX_GROUPS];
	logic [TIME_BITS-1:0]  gt_d [MAX_GROUPS];

	logic [SAMPLE_BITS-1:0] sv [3];
	logic [1:0]             ucnt;
	logic [2:0]             first;
	logic [23:0]            div_prod;
	logic [10:0]            div3;
	logic [MAX_GROUPS-1:0]  en4;

	assign en4      = MAX_GROUPS'(en_q);
	assign div_prod = 24'(word[11:0]) * 24'(DIV3_RECIP);
	assign div3     = div_prod[DIV3_SHIFT +: 11];

	// Triplet unpack: 2 + 3 + 3 samples from three words
	always_comb begin
		carry_u = carry_q;
		sv[2]   = '0;
		case (wig_q)
			2'd0: begin
				sv[0]   = word[11:0];
				sv[1]   = word[23:12];
				carry_u = word[31:24];
				first   = 3'd0;
				ucnt    = 2'd2;
			end
			2'd1: begin
				sv[0]   = {word[3:0], carry_q};
				sv[1]   = word[15:4];
				sv[2]   = word[27:16];
				carry_u = {4'b0, word[31:28]};
				first   = 3'd2;
				ucnt    = 2'd3;
			end
			default: begin
				sv[0]   = {word[7:0], 4'b0} | {4'b0, carry_q};
				sv[1]   = word[19:8];
				sv[2]   = word[31:20];
				first   = 3'd5;
				ucnt    = 2'd3;
			end
		endcase
	end

	always_comb begin
		logic [RES_CNT_W-1:0] n;
		logic                 do_finish;
		grp_sel_t             g0;
		grp_sel_t             ng;
		logic [10:0]          cnt_inc;
		logic [11:0]          tidx;
		logic [59:0]          tv [MAX_GROUPS];

		ph_d      = ph_q;
		wig_d     = wig_q;
		cnt_d     = cnt_q;
		spc_d     = spc_q;
		en_d      = en_q;
		cg_d      = cg_q;
		trg_d     = trg_q;
		carry_d   = carry_q;
		freq_d    = freq_q;
		gt_d      = gt_q;
		set       = '0;
		n         = '0;
		do_finish = 1'b0;
		g0        = next_group(en4, 3'd0);
		ng        = g0;
		cnt_inc   = '0;
		tidx      = '0;

		if (sof) begin
			if (word[31:28] != HDR_MARKER) begin
				set.item[n] = mk_res(KIND_BAD, 2'd0, 3'd0, 11'd0, 60'(word), 1'b0,
					2'd0, 1'b1);
				n    = n + 1'b1;
				ph_d = PH_IDLE;
			end else begin
				for (int g = 0; g < MAX_GROUPS; g++) gt_d[g] = '0;
				set.item[n] = mk_res(KIND_LEN, 2'd0, 3'd0, 11'd0, 60'(word[27:0]),
					1'b0, 2'd0, 1'b0);
				n    = n + 1'b1;
				ph_d = PH_MASK;
			end
		end else begin
			unique case (ph_q)
				PH_MASK: begin
					en_d = word[NUM_GROUPS-1:0];
					set.item[n] = mk_res(KIND_GMASK, 2'd0, 3'd0, 11'd0, 60'(word[3:0]),
						1'b0, 2'd0, 1'b0);
					n = n + 1'b1;
					set.item[n] = mk_res(KIND_LVDS, 2'd0, 3'd0, 11'd0, 60'(word[23:8]),
						1'b0, 2'd0, 1'b0);
					n    = n + 1'b1;
					ph_d = PH_EVNR;
				end
				PH_EVNR: begin
					set.item[n] = mk_res(KIND_EVNUM, 2'd0, 3'd0, 11'd0, 60'(word[21:0]),
						1'b0, 2'd0, 1'b0);
					n    = n + 1'b1;
					ph_d = PH_TTAG;
				end
				PH_TTAG: begin
					set.item[n] = mk_res(KIND_TTAG, 2'd0, 3'd0, 11'd0, 60'(word),
						1'b0, 2'd0, 1'b0);
					n = n + 1'b1;
					if (g0.found) begin
						cg_d = g0.idx;
						ph_d = PH_GHDR;
					end else begin
						do_finish = 1'b1;
					end
				end
				PH_GHDR: begin
					// Sample count and frequency come from the first group only
					if (g0.found && (g0.idx == cg_q)) begin
						spc_d  = div3;
						freq_d = word[17:16];
					end
					trg_d = word[12];
					set.item[n] = mk_res(KIND_GHDR, cg_q, 3'd0, 11'd0, 60'(word[29:20]),
						word[12], freq_d, 1'b0);
					n     = n + 1'b1;
					wig_d = 2'd0;
					cnt_d = '0;
					ph_d  = (spc_d == '0) ? PH_GTIME : PH_SAMP;
				end
				PH_SAMP: begin
					carry_d = carry_u;
					for (int i = 0; i < 3; i++) begin
						if (2'(i) < ucnt) begin
							set.item[n] = mk_res(KIND_SAMPLE, cg_q, first + 3'(i), cnt_q,
								60'(sv[i]), 1'b0, 2'd0, 1'b0);
							n = n + 1'b1;
						end
					end
					if (wig_q >= 2'd2) begin
						wig_d   = 2'd0;
						cnt_inc = cnt_q + 11'd1;
						if (cnt_inc >= spc_q) begin
							cnt_d = '0;
							ph_d  = trg_q ? PH_TRIG : PH_GTIME;
						end else begin
							cnt_d = cnt_inc;
						end
					end else begin
						wig_d = wig_q + 2'd1;
					end
				end
				PH_TRIG: begin
					carry_d = carry_u;
					// Drop trigger samples past the sample count
					for (int i = 0; i < 3; i++) begin
						tidx = 12'(cnt_q) + 12'(first) + 12'(i);
						if ((2'(i) < ucnt) && (tidx < 12'(spc_q))) begin
							set.item[n] = mk_res(KIND_TSAMPLE, cg_q, 3'd0, tidx[10:0],
								60'(sv[i]), 1'b0, 2'd0, 1'b0);
							n = n + 1'b1;
						end
					end
					if (wig_q >= 2'd2) begin
						wig_d   = 2'd0;
						cnt_inc = cnt_q + 11'(CHANNELS_PER_GROUP);
						if (cnt_inc >= spc_q) begin
							cnt_d = '0;
							ph_d  = PH_GTIME;
						end else begin
							cnt_d = cnt_inc;
						end
					end else begin
						wig_d = wig_q + 2'd1;
					end
				end
				PH_GTIME: begin
					gt_d[cg_q] = word[TIME_BITS-1:0];
					ng = next_group(en4, 3'(cg_q) + 3'd1);
					if (ng.found) begin
						cg_d = ng.idx;
						ph_d = PH_GHDR;
					end else begin
						do_finish = 1'b1;
					end
				end
				default: begin
					// idle: drop words outside an event
				end
			endcase
		end

		// Event end: merge differing pairs into extended times
		for (int g = 0; g < MAX_GROUPS; g++) tv[g] = 60'(gt_d[g]);
		if (gt_d[0] != gt_d[1]) begin
			tv[0] = {gt_d[1], gt_d[0]};
			tv[1] = '0;
		end
		if (gt_d[2] != gt_d[3]) begin
			tv[2] = {gt_d[3], gt_d[2]};
			tv[3] = '0;
		end
		if (do_finish) begin
			for (int g = 0; g < MAX_GROUPS; g++) begin
				set.item[n] = mk_res(KIND_TTIME, 2'(g), 3'd0, 11'd0, tv[g], 1'b0, 2'd0,
					g == MAX_GROUPS - 1);
				n = n + 1'b1;
			end
			ph_d = PH_IDLE;
		end
		set.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_IDLE;
			wig_q   <= '0;
			cnt_q   <= '0;
			spc_q   <= '0;
			en_q    <= '0;
			cg_q    <= '0;
			trg_q   <= 1'b0;
			carry_q <= '0;
			freq_q  <= 2'd3;
			for (int g = 0; g < MAX_GROUPS; g++) gt_q[g] <= '0;
		end else if (advance) begin
			ph_q    <= ph_d;
			wig_q   <= wig_d;
			cnt_q   <= cnt_d;
			spc_q   <= spc_d;
			en_q    <= en_d;
			cg_q    <= cg_d;
			trg_q   <= trg_d;
			carry_q <= carry_d;
			freq_q  <= freq_d;
			gt_q    <= gt_d;
		end
	end

endmodule

// File: design/deu_burst.sv
// Result register: holds the results of one word and shifts them out one per transfer.
// Depends on deu_pkg.
`timescale 1ns / 1ps

module deu_burst (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  deu_pkg::res_set_t set,
	input  logic              result_stall,
	output logic              can_load,
	output logic              result_valid,
	output deu_pkg::res_t     result
);
	import deu_pkg::*;

	logic [RES_CNT_W-1:0] count_q;
	res_t [MAX_RES-1:0]   item_q;
	logic                 take;

	assign result_valid = (count_q != '0);
	assign result       = item_q[0];
	assign take         = result_valid && !result_stall;
	// Free when empty, or when the last held result leaves this cycle
	assign can_load     = (count_q == '0) || ((count_q == RES_CNT_W'(1)) && take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load) begin
			count_q <= set.cnt;
		end else if (take) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= set.item;
		end else if (take) begin
			for (int i = 0; i < MAX_RES - 1; i++) item_q[i] <= item_q[i + 1];
		end
	end

endmodule

// File: design/digitizer_event_unpacker_unit.sv
// Top level of the digitizer event unpacker: input register, decoder, result register.
// Depends on deu_pkg, deu_decode and deu_burst.
//
//   channel   signals                                     direction
//   item      data_word, start_of_event; item_valid/stall  in  (one word per transfer)
//   result    kind .. last; result_valid/result_stall      out (one result per transfer)
//
// A word is registered, decoded combinationally into up to five results and loaded into
// the result register, where its first result is valid; a word waits in the input register
// until its results can be loaded. Results leave one per cycle while result_stall is low,
// and the result register sets this pace; words with no results pass without loading.
// Reset clears all parse state, frequency code to three. A result stall holds the current
// result and stalls the item side once the next word's results cannot be loaded.
`timescale 1ns / 1ps

module digitizer_event_unpacker_unit #(
	parameter int NUM_GROUPS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] data_word,
	input  logic        start_of_event,
	input  logic        item_valid,
	output logic        item_stall,
	output logic [3:0]  kind,
	output logic [1:0]  group,
	output logic [2:0]  channel,
	output logic [10:0] sample_index,
	output logic [59:0] value,
	output logic        trigger_present,
	output logic [1:0]  frequency,
	output logic        last,
	output logic        result_valid,
	input  logic        result_stall
);
	import deu_pkg::*;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic        sof_s1;
	logic        advance;
	logic        can_load;
	res_set_t    set;
	res_t        result;

	// Advance the held word when its results fit, or when it has none
	assign advance    = valid_s1 && ((set.cnt == '0) || can_load);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	// Payload of the input register: load on each transfer
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			word_s1 <= data_word;
			sof_s1  <= start_of_event;
		end
	end

	deu_decode #(
		.NUM_GROUPS(NUM_GROUPS)
	) u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.word    (word_s1),
		.sof     (sof_s1),
		.set     (set)
	);

	deu_burst u_burst (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && (set.cnt != '0)),
		.set          (set),
		.result_stall (result_stall),
		.can_load     (can_load),
		.result_valid (result_valid),
		.result       (result)
	);

	// Split the held result onto the ports
	assign kind            = result.kind;
	assign group           = result.group;
	assign channel         = result.channel;
	assign sample_index    = result.sample_index;
	assign value           = result.value;
	assign trigger_present = result.trigger_present;
	assign frequency       = result.frequency;
	assign last            = result.last;

endmodule

// File: design/deu_checker.sv
// Port-level checks on the result channel of the event unpacker, bound to the top level.
// Depends on deu_pkg and digitizer_event_unpacker_unit_defines.svh.
`timescale 1ns / 1ps
`include "digitizer_event_unpacker_unit_defines.svh"

module deu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic [3:0]  kind,
	input logic [1:0]  group,
	input logic [59:0] value,
	input logic        last,
	input logic        result_valid,
	input logic        result_stall
);
	import deu_pkg::*;

	// A stalled result stays put
	`DEU_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(kind) && $stable(value))

	// A bad header is a lone, final result
	`DEU_ASSERT_NOW(a_bad_last, result_valid && kind == KIND_BAD, last && group == 2'd0)

	// Trigger times close the event with the last group
	`DEU_ASSERT_NOW(a_ttime_last, result_valid && kind == KIND_TTIME, last == (group == 2'd3))

	// Only an error or the final trigger time ends an event
	`DEU_ASSERT_NOW(a_last_kind, result_valid && last, kind == KIND_BAD || kind == KIND_TTIME)

	// Trigger times go out back to back
	`DEU_ASSERT_NEXT(a_ttime_run, result_valid && !result_stall && kind == KIND_TTIME && !last, result_valid && kind == KIND_TTIME)

endmodule

bind digitizer_event_unpacker_unit deu_checker u_deu_checker (.*);
